// File: sv/fss_pkg.sv
// -----------------------------------------------------------------------------
// fss_pkg
// Shared constants, types and helper functions of the fuzzy subsequence scorer.
// -----------------------------------------------------------------------------
package fss_pkg;

  // Search term and text limits.
  localparam int unsigned MaxTermLength = 8;
  localparam int unsigned TermLenW      = 4;
  localparam int unsigned TermCharsW    = 8 * MaxTermLength;
  localparam int unsigned TermIdxW      = $clog2(MaxTermLength);
  localparam int unsigned MaxTextCount  = 1023;
  localparam int unsigned TextCntW      = $clog2(MaxTextCount + 1);

  // Score arithmetic.
  localparam int unsigned ScoreW        = 8;
  localparam int unsigned RunW          = 3;
  localparam int unsigned GainW         = 5;
  localparam int unsigned RunBonus      = 3;
  localparam int unsigned WordBonus     = 5;
  localparam int unsigned DensityScale  = 100;

  // Density divider: dividend is scale times term length, divisor is count plus one.
  localparam int unsigned DivNW         = TextCntW;
  localparam int unsigned DivDW         = TextCntW + 1;
  localparam int unsigned DivSteps      = DivNW;
  localparam int unsigned DivCntW       = $clog2(DivSteps + 1);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW       = 1;
  localparam logic [CfgIdxW-1:0] CfgTermChars  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTermLength = 1'd1;

  // Word break bytes.
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChUnder     = 8'h5F;
  localparam logic [7:0] ChDash      = 8'h2D;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperZ    = 8'h5A;
  localparam logic [7:0] CaseBit     = 8'h20;

  // Request into the divider.
  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  // Response from the divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

  // Map ASCII upper case letters to lower case.
  function automatic logic [7:0] fold_ascii(input logic [7:0] c);
    fold_ascii = ((c >= ChUpperA) && (c <= ChUpperZ)) ? (c | CaseBit) : c;
  endfunction

  // True for bytes that end a word.
  function automatic logic is_break(input logic [7:0] c);
    is_break = (c == ChSpace) || (c == ChTab) || (c == ChNewline) || (c == ChReturn) ||
               (c == ChUnder) || (c == ChDash) || (c == ChSlash) || (c == ChDot) ||
               (c == ChBackslash);
  endfunction

endpackage

// File: sv/fss_div.sv
// -----------------------------------------------------------------------------
// fss_div
// Restoring divider that retires one quotient bit per cycle.
// -----------------------------------------------------------------------------
module fss_div
  import fss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivDW-1:0]   rem_q, rem_d;
  logic [DivDW-1:0]   dvs_q, dvs_d;
  logic [DivNW-1:0]   quo_q, quo_d;
  logic [DivDW:0]     trial;
  logic               qbit;

  // One shift and trial subtraction per cycle.
  always_comb begin
    trial  = {rem_q, quo_q[DivNW-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = qbit ? DivDW'(trial - {1'b0, dvs_q}) : DivDW'(trial);
      quo_d = {quo_q[DivNW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: sv/fuzzy_subsequence_scorer.sv
// -----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Greedy case-folded subsequence match of a text stream against a short term.
// -----------------------------------------------------------------------------
// Text bytes arrive one per transaction on the slave stream, and every byte that
// is not marked last is accepted without leaving the idle state. The byte marked
// last closes the text and yields one result on the master stream. When the term
// was fully matched, the density bonus 100*length/(count+1) is computed by a
// restoring divider that retires one quotient bit per cycle for ten steps; the
// result is then emitted once the output register is free, while an unmatched
// text goes straight to emit. The next text may begin while the result still
// waits in the output register. The user must write the term registers through
// the configuration port only while idle; the block itself does not enforce it.
module fuzzy_subsequence_scorer
  import fss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [TermCharsW-1:0] cfg_data_i,
  // Text input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] text_char
  input  logic                  s_axis_tlast,   // last_char
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] match_score
  output logic [0:0]            m_axis_tuser    // [0] matched
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [TermCharsW-1:0] term_chars_q;
  logic [TermLenW-1:0]   term_len_q;
  logic [TermLenW-1:0]   mcount_q, mcount_d;
  logic [RunW-1:0]       run_q, run_d;
  logic [ScoreW-1:0]     score_q, score_d;
  logic [TextCntW-1:0]   tcount_q, tcount_d;
  logic                  prev_brk_q, prev_brk_d;
  logic [ScoreW-1:0]     fin_score_q, fin_score_d;
  logic                  fin_match_q, fin_match_d;
  logic                  out_valid_q, out_valid_d;
  logic [ScoreW-1:0]     out_score_q;
  logic                  out_match_q;

  logic                  in_fire;
  logic                  out_load;
  logic                  usable;
  logic                  hit;
  logic                  full_match;
  logic [7:0]            want;
  logic [GainW-1:0]      gain;
  logic [ScoreW:0]       score_sum;
  logic [ScoreW-1:0]     score_upd;
  logic [DivNW:0]        final_sum;
  logic [ScoreW-1:0]     final_sat;
  logic [DivNW:0]        dividend_w;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_chars_q <= '0;
      term_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTermChars:  term_chars_q <= cfg_data_i;
        CfgTermLength: term_len_q   <= cfg_data_i[TermLenW-1:0];
        default:       ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // Per-byte match step against the next wanted term character.
  always_comb begin
    usable    = (term_len_q >= TermLenW'(1)) && (term_len_q <= TermLenW'(MaxTermLength));
    want      = term_chars_q[8*mcount_q[TermIdxW-1:0] +: 8];
    hit       = usable && (mcount_q < term_len_q) &&
                (fold_ascii(s_axis_tdata) == fold_ascii(want));
    gain      = GainW'(1) + GainW'(RunBonus) * GainW'(run_q) +
                (prev_brk_q ? GainW'(WordBonus) : GainW'(0));
    score_sum = {1'b0, score_q} + (ScoreW+1)'(gain);
    score_upd = score_sum[ScoreW] ? {ScoreW{1'b1}} : score_sum[ScoreW-1:0];
    tcount_d  = (tcount_q < TextCntW'(MaxTextCount)) ? tcount_q + 1'b1 : tcount_q;
    mcount_d  = hit ? mcount_q + 1'b1 : mcount_q;
    run_d     = run_q;
    if (usable && (mcount_q < term_len_q)) begin
      if (hit) begin
        run_d = (run_q == {RunW{1'b1}}) ? run_q : run_q + 1'b1;
      end else begin
        run_d = '0;
      end
    end
    score_d    = hit ? score_upd : score_q;
    prev_brk_d = is_break(s_axis_tdata);
    full_match = usable && (mcount_d == term_len_q);
  end

  // Density dividend and divider request.
  assign dividend_w       = (DivNW+1)'(term_len_q) * (DivNW+1)'(DensityScale);
  assign div_req.start    = in_fire && s_axis_tlast && full_match;
  assign div_req.dividend = dividend_w[DivNW-1:0];
  assign div_req.divisor  = {1'b0, tcount_d} + DivDW'(1);

  fss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Running score plus density, saturated.
  assign final_sum = (DivNW+1)'(fin_score_q) + {1'b0, div_rsp.quotient};
  assign final_sat = (final_sum > (DivNW+1)'({ScoreW{1'b1}})) ? {ScoreW{1'b1}}
                                                              : final_sum[ScoreW-1:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    fin_score_d = fin_score_q;
    fin_match_d = fin_match_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          fin_match_d = full_match;
          fin_score_d = full_match ? score_d : '0;
          state_d     = full_match ? ST_DIVIDE : ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          fin_score_d = final_sat;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and text state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mcount_q    <= '0;
      run_q       <= '0;
      score_q     <= '0;
      tcount_q    <= '0;
      prev_brk_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        if (s_axis_tlast) begin
          mcount_q   <= '0;
          run_q      <= '0;
          score_q    <= '0;
          tcount_q   <= '0;
          prev_brk_q <= 1'b1;
        end else begin
          mcount_q   <= mcount_d;
          run_q      <= run_d;
          score_q    <= score_d;
          tcount_q   <= tcount_d;
          prev_brk_q <= prev_brk_d;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    fin_score_q <= fin_score_d;
    fin_match_q <= fin_match_d;
    if (out_load) begin
      out_score_q <= fin_score_q;
      out_match_q <= fin_match_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_score_q;
  assign m_axis_tuser[0] = out_match_q;

`ifndef SYNTH
  // A matched result always carries a nonzero score.
  a_match_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata != 8'd0))
    else $error("matched result with zero score");

  // An unmatched result carries a zero score.
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
    else $error("unmatched result with nonzero score");

  // A full match on the last byte starts the divider and enters the divide state.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> ((state_q == ST_DIVIDE) && div_rsp.busy))
    else $error("divider not started for a matched text");
`endif

endmodule
